// ===== hdl/hrhp_pkg.sv =====
// ----------------------------------------------------------------------------
// HTTP response header parser package
// Shared constants, result roles and the command/status words that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package hrhp_pkg;

	localparam int HOLD_DEPTH_DEF = 16;

	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_VT    = 8'h0B;
	localparam logic [7:0] CH_FF    = 8'h0C;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_COLON = 8'h3A;

	localparam logic [1:0]  SEP_LIMIT  = 2'd2;
	localparam logic [15:0] STATUS_MAX = 16'hFFFF;

	typedef enum logic [3:0] {
		ROLE_VERSION,
		ROLE_STATUS,
		ROLE_REASON,
		ROLE_NAME,
		ROLE_VALUE,
		ROLE_START_END,
		ROLE_HDR_END,
		ROLE_LINE_END,
		ROLE_BODY
	} role_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_RESTART,
		OP_BODY,
		OP_LINE_END,
		OP_CONTENT,
		OP_FLUSH_ONE,
		OP_LATCH
	} dp_op_t;

	typedef enum logic [1:0] {
		SRC_IN,
		SRC_LATCHED,
		SRC_CR
	} src_t;

	typedef struct packed {
		dp_op_t op;
		src_t   src;
		logic   emit;
		logic   last;
		logic   set_cr;
	} dp_cmd_t;

	typedef struct packed {
		logic out_free;
		logic body;
		logic cr_held;
		logic in_is_lf;
		logic in_is_cr;
		logic needs_flush;
		logic emits;
		logic flush_done;
		logic latched_is_cr;
		logic after_cr_emits;
	} dp_status_t;

endpackage

// ===== hdl/hrhp_dp.sv =====
// ----------------------------------------------------------------------------
// HTTP response header parser datapath
// Line state, status conversion, trailing whitespace hold line and the
// output register.
// ----------------------------------------------------------------------------
module hrhp_dp #(
	parameter int HOLD_DEPTH = hrhp_pkg::HOLD_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [7:0]          data_byte,
	input  logic                out_stall,
	input  hrhp_pkg::dp_cmd_t   cmd,
	output hrhp_pkg::dp_status_t st,
	output logic                out_valid,
	output logic [3:0]          role,
	output logic [7:0]          out_byte,
	output logic signed [16:0]  status_code,
	output logic [1:0]          separators_seen,
	output logic                colon_seen,
	output logic                trim_overflow,
	output logic                last
);
	import hrhp_pkg::*;

	localparam int CW = $clog2(HOLD_DEPTH + 1);
	localparam int IW = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;
	localparam logic [CW-1:0] DEPTH_C = CW'(HOLD_DEPTH);

	localparam logic [1:0] PH_START  = 2'd0;
	localparam logic [1:0] PH_HEADER = 2'd1;
	localparam logic [1:0] PH_BODY   = 2'd2;

	logic [1:0]            phase_q;
	logic                  cr_held_q;
	logic                  line_bytes_q;
	logic [1:0]            spaces_q;
	logic                  colon_q;
	logic                  value_begun_q;
	logic [HOLD_DEPTH-1:0] held_q;		// one bit per held word: set for tab
	logic [CW-1:0]         held_cnt_q;
	logic [CW-1:0]         flush_idx_q;
	logic [15:0]           acc_q;
	logic                  neg_q;
	logic                  digits_done_q;
	logic                  started_q;
	logic                  ovf_q;
	logic [7:0]            byte_q;

	logic                  out_valid_q;
	role_t                 out_role_q;
	logic [7:0]            out_byte_q;
	logic [16:0]           out_status_q;
	logic [1:0]            out_seps_q;
	logic                  out_colon_q;
	logic                  out_ovf_q;
	logic                  out_last_q;

	logic [7:0]  c;
	logic        blank;
	logic        lat_blank;
	logic        in_start;
	logic        in_name;
	logic        held_full;
	logic        emits;
	logic        needs_flush;
	role_t       content_role;
	logic        out_free;
	logic [19:0] acc_sum;
	logic [15:0] acc_next;
	logic [16:0] acc_ext;
	logic [16:0] status_val;

	role_t       o_role;
	logic [7:0]  o_byte;
	logic [16:0] o_status;
	logic [1:0]  o_seps;
	logic        o_colon;
	logic        o_ovf;

	always_comb begin
		case (cmd.src)
			SRC_LATCHED: c = byte_q;
			SRC_CR:      c = CH_CR;
			default:     c = data_byte;
		endcase
	end

	assign blank     = (c == CH_SP) || (c == CH_TAB);
	assign lat_blank = (byte_q == CH_SP) || (byte_q == CH_TAB);
	assign in_start  = (phase_q == PH_START);
	assign in_name   = (phase_q == PH_HEADER) && !colon_q;
	assign held_full = (held_cnt_q == DEPTH_C);
	assign out_free  = !out_valid_q || !out_stall;

	always_comb begin
		if (in_start) begin
			emits = !((spaces_q < SEP_LIMIT) && (c == CH_SP));
		end else if (in_name) begin
			emits = (c != CH_COLON);
		end else begin
			emits = blank ? (value_begun_q && held_full) : 1'b1;
		end
	end

	assign needs_flush = !in_start && !in_name && (held_cnt_q != '0) && (!blank || held_full);

	always_comb begin
		if (in_start) begin
			case (spaces_q)
				2'd0:    content_role = ROLE_VERSION;
				2'd1:    content_role = ROLE_STATUS;
				default: content_role = ROLE_REASON;
			endcase
		end else if (in_name) begin
			content_role = ROLE_NAME;
		end else begin
			content_role = ROLE_VALUE;
		end
	end

	always_comb begin
		st                = '0;
		st.out_free       = out_free;
		st.body           = phase_q[1];
		st.cr_held        = cr_held_q;
		st.in_is_lf       = (data_byte == CH_LF);
		st.in_is_cr       = (data_byte == CH_CR);
		st.needs_flush    = needs_flush;
		st.emits          = emits;
		st.flush_done     = (flush_idx_q == held_cnt_q);
		st.latched_is_cr  = (byte_q == CH_CR);
		// what the latched word yields once the held CR has gone through as content
		if (in_start) begin
			st.after_cr_emits = !((spaces_q < SEP_LIMIT) && (byte_q == CH_SP));
		end else if (in_name) begin
			st.after_cr_emits = (byte_q != CH_COLON);
		end else begin
			st.after_cr_emits = !lat_blank;
		end
	end

	// acc * 10 + digit, saturating
	assign acc_sum  = 20'({acc_q, 3'b000}) + 20'({acc_q, 1'b0}) + 20'(c[3:0]);
	assign acc_next = (acc_sum > 20'(STATUS_MAX)) ? STATUS_MAX : acc_sum[15:0];
	assign acc_ext  = {1'b0, acc_q};
	assign status_val = (spaces_q >= SEP_LIMIT) ?
		(neg_q ? 17'(~acc_ext + 17'd1) : acc_ext) : '0;

	always_comb begin
		o_role   = ROLE_BODY;
		o_byte   = '0;
		o_status = '0;
		o_seps   = '0;
		o_colon  = 1'b0;
		o_ovf    = 1'b0;
		case (cmd.op)
			OP_BODY: begin
				o_role = ROLE_BODY;
				o_byte = c;
			end
			OP_LINE_END: begin
				if (!line_bytes_q) begin
					o_role = ROLE_HDR_END;
				end else if (in_start) begin
					o_role   = ROLE_START_END;
					o_status = status_val;
					o_seps   = spaces_q;
				end else begin
					o_role  = ROLE_LINE_END;
					o_colon = colon_q;
					o_ovf   = ovf_q;
				end
			end
			OP_CONTENT: begin
				o_role = content_role;
				o_byte = c;
			end
			OP_FLUSH_ONE: begin
				o_role = ROLE_VALUE;
				o_byte = held_q[0] ? CH_TAB : CH_SP;
			end
			default: begin
				o_role = ROLE_BODY;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_START;
			cr_held_q     <= 1'b0;
			line_bytes_q  <= 1'b0;
			spaces_q      <= '0;
			colon_q       <= 1'b0;
			value_begun_q <= 1'b0;
			held_cnt_q    <= '0;
			flush_idx_q   <= '0;
			acc_q         <= '0;
			neg_q         <= 1'b0;
			digits_done_q <= 1'b0;
			started_q     <= 1'b0;
			ovf_q         <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (cmd.op)
				OP_RESTART, OP_LINE_END: begin
					if (cmd.op == OP_RESTART) begin
						phase_q <= PH_START;
					end else if (!line_bytes_q) begin
						phase_q <= PH_BODY;
					end else if (in_start) begin
						phase_q <= PH_HEADER;
					end
					cr_held_q     <= 1'b0;
					line_bytes_q  <= 1'b0;
					spaces_q      <= '0;
					colon_q       <= 1'b0;
					value_begun_q <= 1'b0;
					held_cnt_q    <= '0;
					flush_idx_q   <= '0;
					acc_q         <= '0;
					neg_q         <= 1'b0;
					digits_done_q <= 1'b0;
					started_q     <= 1'b0;
					ovf_q         <= 1'b0;
				end
				OP_LATCH: begin
					cr_held_q   <= 1'b0;
					flush_idx_q <= '0;
				end
				OP_FLUSH_ONE: begin
					flush_idx_q <= flush_idx_q + CW'(1);
				end
				OP_CONTENT: begin
					line_bytes_q <= 1'b1;
					flush_idx_q  <= '0;
					if (in_start) begin
						if ((spaces_q < SEP_LIMIT) && (c == CH_SP)) begin
							spaces_q <= spaces_q + 2'd1;
						end else if (spaces_q == 2'd1 && !digits_done_q) begin
							// atoi: skip leading blanks, one sign, stop at first non-digit
							if (!started_q && (c inside {CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR})) begin
								started_q <= 1'b0;
							end else if (!started_q && (c == CH_PLUS || c == CH_MINUS)) begin
								started_q <= 1'b1;
								neg_q     <= (c == CH_MINUS);
							end else begin
								started_q <= 1'b1;
								if (c >= CH_ZERO && c <= CH_NINE) begin
									acc_q <= acc_next;
								end else begin
									digits_done_q <= 1'b1;
								end
							end
						end
					end else if (in_name) begin
						if (c == CH_COLON) begin
							colon_q <= 1'b1;
						end
					end else if (blank) begin
						if (value_begun_q) begin
							if (!held_full) begin
								held_cnt_q <= held_cnt_q + CW'(1);
							end else begin
								held_cnt_q <= '0;
								ovf_q      <= 1'b1;
							end
						end
					end else begin
						value_begun_q <= 1'b1;
						held_cnt_q    <= '0;
					end
				end
				default: begin
				end
			endcase
			if (cmd.set_cr) begin
				cr_held_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_LATCH) begin
			byte_q <= data_byte;
		end
		if (cmd.op == OP_FLUSH_ONE) begin
			held_q <= held_q >> 1;
		end else if (cmd.op == OP_CONTENT && !in_start && !in_name && blank &&
				value_begun_q && !held_full) begin
			held_q[held_cnt_q[IW-1:0]] <= (c == CH_TAB);
		end
		if (cmd.emit) begin
			out_role_q   <= o_role;
			out_byte_q   <= o_byte;
			out_status_q <= o_status;
			out_seps_q   <= o_seps;
			out_colon_q  <= o_colon;
			out_ovf_q    <= o_ovf;
			out_last_q   <= cmd.last;
		end
	end

	assign out_valid       = out_valid_q;
	assign role            = out_role_q;
	assign out_byte        = out_byte_q;
	assign status_code     = out_status_q;
	assign separators_seen = out_seps_q;
	assign colon_seen      = out_colon_q;
	assign trim_overflow   = out_ovf_q;
	assign last            = out_last_q;

endmodule

// ===== hdl/hrhp_ctrl.sv =====
// ----------------------------------------------------------------------------
// HTTP response header parser controller
// Takes words in, and sequences the held CR, whitespace flushes and the
// final result of each word.
// ----------------------------------------------------------------------------
module hrhp_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 op,
	input  hrhp_pkg::dp_status_t st,
	output logic                 in_stall,
	output hrhp_pkg::dp_cmd_t    cmd
);
	import hrhp_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_DO_CR,
		S_DO_B
	} state_t;

	state_t state_q;
	state_t state_nxt;

	always_comb begin
		cmd       = '0;
		cmd.op    = OP_NONE;
		cmd.src   = SRC_IN;
		in_stall  = 1'b1;
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				in_stall = !st.out_free;
				if (in_valid && st.out_free) begin
					if (op) begin
						cmd.op = OP_RESTART;
					end else if (st.body) begin
						cmd.op   = OP_BODY;
						cmd.emit = 1'b1;
						cmd.last = 1'b1;
					end else if (st.cr_held && st.in_is_lf) begin
						cmd.op   = OP_LINE_END;
						cmd.emit = 1'b1;
						cmd.last = 1'b1;
					end else if (st.cr_held) begin
						cmd.op    = OP_LATCH;
						state_nxt = S_DO_CR;
					end else if (st.in_is_cr) begin
						cmd.set_cr = 1'b1;
					end else if (st.needs_flush) begin
						cmd.op    = OP_LATCH;
						state_nxt = S_DO_B;
					end else begin
						cmd.op   = OP_CONTENT;
						cmd.emit = st.emits;
						cmd.last = st.emits;
					end
				end
			end
			S_DO_CR: begin
				// held CR goes through as content, then the latched word
				cmd.src = SRC_CR;
				if (st.out_free) begin
					if (st.needs_flush && !st.flush_done) begin
						cmd.op   = OP_FLUSH_ONE;
						cmd.emit = 1'b1;
					end else begin
						cmd.op   = OP_CONTENT;
						cmd.emit = 1'b1;
						cmd.last = st.latched_is_cr || !st.after_cr_emits;
						if (st.latched_is_cr) begin
							cmd.set_cr = 1'b1;
							state_nxt  = S_IDLE;
						end else begin
							state_nxt = S_DO_B;
						end
					end
				end
			end
			S_DO_B: begin
				cmd.src = SRC_LATCHED;
				if (st.needs_flush && !st.flush_done) begin
					if (st.out_free) begin
						cmd.op   = OP_FLUSH_ONE;
						cmd.emit = 1'b1;
					end
				end else if (!st.emits || st.out_free) begin
					cmd.op    = OP_CONTENT;
					cmd.emit  = st.emits;
					cmd.last  = st.emits;
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

// ===== hdl/http_response_header_parser.sv =====
// ----------------------------------------------------------------------------
// HTTP response header parser
// Splits a response byte stream into start line, header and body words.
// ----------------------------------------------------------------------------
// Input channel: in_valid/in_stall with op and data_byte. op low feeds one
// response byte, op high restarts the parser for a new response (no result).
// Output channel: out_valid/out_stall with role, out_byte, status_code,
// separators_seen, colon_seen, trim_overflow and last; last marks the final
// result caused by one input word.
// Each result is held in a registered output.
// Throughput: one word per cycle in the common case while the receiver does
// not stall. A word after a held CR that is not LF is latched, the CR goes
// out as content and then the word itself; a second CR is held again.
// A word that releases held trailing blanks of a header value is latched and
// each held blank (up to HOLD_DEPTH) goes out before it; a released CR in a
// header value also has the held blanks sent out in front of it. These
// results pass the single output register one per cycle while input stalls.
// A word is taken only while the output register is empty or being drained,
// so a stalled receiver stalls the input at once.
// Reset clears all parser state to the start of a response; held whitespace
// storage is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module http_response_header_parser #(
	parameter int HOLD_DEPTH = hrhp_pkg::HOLD_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               op,
	input  logic [7:0]         data_byte,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [3:0]         role,
	output logic [7:0]         out_byte,
	output logic signed [16:0] status_code,
	output logic [1:0]         separators_seen,
	output logic               colon_seen,
	output logic               trim_overflow,
	output logic               last
);
	import hrhp_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t st;

	hrhp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.op       (op),
		.st       (st),
		.in_stall (in_stall),
		.cmd      (cmd)
	);

	hrhp_dp #(
		.HOLD_DEPTH (HOLD_DEPTH)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.data_byte       (data_byte),
		.out_stall       (out_stall),
		.cmd             (cmd),
		.st              (st),
		.out_valid       (out_valid),
		.role            (role),
		.out_byte        (out_byte),
		.status_code     (status_code),
		.separators_seen (separators_seen),
		.colon_seen      (colon_seen),
		.trim_overflow   (trim_overflow),
		.last            (last)
	);

`ifndef SYNTHESIS
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> st.out_free)
		else $error("result loaded over an untaken result");

	a_flush_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_FLUSH_ONE) |-> (cmd.emit && !cmd.last))
		else $error("flushed blank marked as final result");

	a_restart_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_RESTART) |-> !cmd.emit)
		else $error("restart produced a result");

	a_line_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (role == ROLE_START_END || role == ROLE_HDR_END ||
			role == ROLE_LINE_END)) |-> last)
		else $error("line end result not marked last");
`endif

endmodule

// ===== tb/tb_http_response_header_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench: HTTP response header parser
// A short scripted response followed by generated ones (start lines with odd
// status text, header lines with padded values and long blank runs, body
// bytes, restarts and junk) is fed one byte per word. Every result word is
// predicted in step with the parser and checked in order, under random gaps
// on the input and random stalls on the output.
// ----------------------------------------------------------------------------
module tb_http_response_header_parser;
	import hrhp_pkg::*;

	localparam int HOLD        = HOLD_DEPTH_DEF;
	localparam int QUIET_LIMIT = 2000;
	localparam int TAIL        = 8;
	localparam int PHASE_BYTES = 55;

	localparam logic CMD_BYTE    = 1'b0;
	localparam logic CMD_RESTART = 1'b1;

	typedef enum logic [1:0] {PH_START, PH_HEADER, PH_BODY} parse_phase_t;

	typedef struct packed {
		role_t       role;
		logic [7:0]  octet;
		logic [16:0] status;
		logic [1:0]  seps;
		logic        colon;
		logic        trim;
		logic        last;
	} word_t;

	typedef struct packed {
		logic       cmd;
		logic [7:0] octet;
		logic       typed;
		word_t      want;
	} row_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic               op = CMD_BYTE;
	logic [7:0]         data_byte = 8'h00;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [3:0]         role;
	logic [7:0]         out_byte;
	logic signed [16:0] status_code;
	logic [1:0]         separators_seen;
	logic               colon_seen;
	logic               trim_overflow;
	logic               last;

	// parser shadow state
	parse_phase_t ph;
	logic         cr_pending;
	logic         line_busy;
	logic [1:0]   spaces;
	logic         colon_hit;
	logic         value_started;
	logic [7:0]   blanks [HOLD];
	int           blank_cnt;
	int unsigned  status_acc;
	logic         status_neg;
	logic         status_stopped;
	logic         status_begun;
	logic         trim_lost;

	word_t step_out[$];
	word_t pending[$];
	row_t  script [27];

	int send_idle = 0;
	int recv_idle = 0;
	int sent = 0;
	int words = 0;
	int hdr_ends = 0;
	int trim_lines = 0;
	int errors = 0;
	int quiet = 0;

	http_response_header_parser dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.op(op),
		.data_byte(data_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.role(role),
		.out_byte(out_byte),
		.status_code(status_code),
		.separators_seen(separators_seen),
		.colon_seen(colon_seen),
		.trim_overflow(trim_overflow),
		.last(last)
	);

	always #1 clk = ~clk;

	function automatic void put_word(role_t r, logic [7:0] b, logic [16:0] st = '0,
			logic [1:0] seps = '0, logic colon = 1'b0, logic trim = 1'b0);
		word_t w;
		w = '0;
		w.role = r;
		w.octet = b;
		w.status = st;
		w.seps = seps;
		w.colon = colon;
		w.trim = trim;
		step_out = {step_out, w};
	endfunction

	function automatic void clear_line();
		line_busy = 1'b0;
		spaces = '0;
		colon_hit = 1'b0;
		value_started = 1'b0;
		blank_cnt = 0;
		status_acc = 0;
		status_neg = 1'b0;
		status_stopped = 1'b0;
		status_begun = 1'b0;
		trim_lost = 1'b0;
	endfunction

	function automatic void reset_parser();
		ph = PH_START;
		cr_pending = 1'b0;
		clear_line();
	endfunction

	// atoi-style: skip leading white space, one sign, stop at first non-digit
	function automatic void feed_status(logic [7:0] b);
		if (status_stopped)
			return;
		if (!status_begun) begin
			if (b == CH_TAB || b == CH_LF || b == CH_VT || b == CH_FF || b == CH_CR ||
					b == CH_SP)
				return;
			if (b == CH_PLUS || b == CH_MINUS) begin
				status_begun = 1'b1;
				status_neg = (b == CH_MINUS);
				return;
			end
			status_begun = 1'b1;
		end
		if (b >= CH_ZERO && b <= CH_NINE) begin
			status_acc = status_acc * 10 + 32'(b - CH_ZERO);
			if (status_acc > 32'(STATUS_MAX))
				status_acc = 32'(STATUS_MAX);
		end else begin
			status_stopped = 1'b1;
		end
	endfunction

	function automatic void flush_blanks();
		for (int i = 0; i < blank_cnt; i++)
			put_word(ROLE_VALUE, blanks[i]);
		blank_cnt = 0;
	endfunction

	function automatic void take_content(logic [7:0] b);
		line_busy = 1'b1;
		if (ph == PH_START) begin
			if (spaces < SEP_LIMIT && b == CH_SP)
				spaces++;
			else if (spaces == 0)
				put_word(ROLE_VERSION, b);
			else if (spaces == 1) begin
				put_word(ROLE_STATUS, b);
				feed_status(b);
			end else
				put_word(ROLE_REASON, b);
			return;
		end
		if (!colon_hit) begin
			if (b == CH_COLON)
				colon_hit = 1'b1;
			else
				put_word(ROLE_NAME, b);
			return;
		end
		if (b == CH_SP || b == CH_TAB) begin
			if (!value_started)
				return;
			if (blank_cnt < HOLD) begin
				blanks[blank_cnt] = b;
				blank_cnt++;
			end else begin
				// hold buffer full: everything goes out, trimming now inexact
				flush_blanks();
				put_word(ROLE_VALUE, b);
				trim_lost = 1'b1;
			end
			return;
		end
		value_started = 1'b1;
		flush_blanks();
		put_word(ROLE_VALUE, b);
	endfunction

	function automatic void close_line();
		int s;
		if (ph == PH_START) begin
			s = 0;
			if (spaces >= SEP_LIMIT)
				s = status_neg ? -int'(status_acc) : int'(status_acc);
			put_word(ROLE_START_END, 8'h00, s[16:0], spaces);
			ph = PH_HEADER;
		end else begin
			put_word(ROLE_LINE_END, 8'h00, '0, '0, colon_hit, trim_lost);
		end
		clear_line();
	endfunction

	function automatic void advance(logic cmd, logic [7:0] b);
		step_out.delete();
		if (cmd == CMD_RESTART) begin
			reset_parser();
			return;
		end
		if (ph == PH_BODY)
			put_word(ROLE_BODY, b);
		else if (cr_pending) begin
			cr_pending = 1'b0;
			if (b == CH_LF) begin
				if (!line_busy) begin
					put_word(ROLE_HDR_END, 8'h00);
					ph = PH_BODY;
					clear_line();
				end else
					close_line();
			end else begin
				// lone CR turns into content, then the new byte on its own
				take_content(CH_CR);
				if (b == CH_CR)
					cr_pending = 1'b1;
				else
					take_content(b);
			end
		end else if (b == CH_CR)
			cr_pending = 1'b1;
		else
			take_content(b);
		if (step_out.size() != 0)
			step_out[step_out.size() - 1].last = 1'b1;
	endfunction

	function automatic row_t row(logic cmd, logic [7:0] b);
		row_t r;
		r = '0;
		r.cmd = cmd;
		r.octet = b;
		return r;
	endfunction

	function automatic row_t row_exp(logic [7:0] b, role_t rl, logic [7:0] ob,
			logic [16:0] st, logic [1:0] seps);
		row_t r;
		r = '0;
		r.cmd = CMD_BYTE;
		r.octet = b;
		r.typed = 1'b1;
		r.want.role = rl;
		r.want.octet = ob;
		r.want.status = st;
		r.want.seps = seps;
		r.want.last = 1'b1;
		return r;
	endfunction

	function automatic void check_field(string name, logic [16:0] want, logic [16:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
			errors++;
		end
	endfunction

	task automatic send(logic cmd, logic [7:0] b, logic typed = 1'b0, word_t want = '0);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		op <= cmd;
		data_byte <= b;
		@(posedge clk);
		while (in_stall !== 1'b0)
			@(posedge clk);
		advance(cmd, b);
		if (typed)
			pending = {pending, want};
		else
			foreach (step_out[i])
				pending = {pending, step_out[i]};
		sent++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [7:0] text_char();
		int r;
		r = $urandom_range(31);
		if (r == 0)
			return CH_CR;
		if (r == 1)
			return CH_LF;
		if (r < 4)
			return 8'($urandom_range(255));
		return 8'($urandom_range(8'h21, 8'h7E));
	endfunction

	function automatic logic [7:0] blank();
		return $urandom_range(1) ? CH_SP : CH_TAB;
	endfunction

	task automatic send_status();
		repeat ($urandom_range(2)) begin
			case ($urandom_range(3))
				0: send(CMD_BYTE, CH_TAB);
				1: send(CMD_BYTE, CH_VT);
				2: send(CMD_BYTE, CH_FF);
				default: send(CMD_BYTE, CH_LF);
			endcase
		end
		if ($urandom_range(2) == 0)
			send(CMD_BYTE, $urandom_range(1) ? CH_MINUS : CH_PLUS);
		repeat ($urandom_range(1, 7))
			send(CMD_BYTE, 8'(CH_ZERO + $urandom_range(9)));
		if ($urandom_range(4) == 0)
			send(CMD_BYTE, text_char());
	endtask

	task automatic send_header_line();
		repeat ($urandom_range(1, 4))
			send(CMD_BYTE, text_char());
		if ($urandom_range(9) != 0)
			send(CMD_BYTE, CH_COLON);
		repeat ($urandom_range(3))
			send(CMD_BYTE, blank());
		repeat ($urandom_range(1, 3)) begin
			repeat ($urandom_range(1, 3))
				send(CMD_BYTE, text_char());
			// now and then a blank run around the hold buffer depth, often long enough to overrun it
			repeat (($urandom_range(3) == 0) ? $urandom_range(HOLD - 1, HOLD + 4)
					: $urandom_range(3))
				send(CMD_BYTE, blank());
		end
		send(CMD_BYTE, CH_CR);
		send(CMD_BYTE, CH_LF);
	endtask

	task automatic send_response();
		if ($urandom_range(7) != 0)
			send(CMD_RESTART, 8'($urandom_range(255)));
		if ($urandom_range(9) == 0)
			repeat ($urandom_range(4, 12))
				send(CMD_BYTE, 8'($urandom_range(255)));
		repeat ($urandom_range(1, 4))
			send(CMD_BYTE, text_char());
		if ($urandom_range(11) != 0) begin
			send(CMD_BYTE, CH_SP);
			send_status();
			if ($urandom_range(11) != 0) begin
				send(CMD_BYTE, CH_SP);
				repeat ($urandom_range(4))
					send(CMD_BYTE, ($urandom_range(3) == 0) ? CH_SP : text_char());
			end
		end
		send(CMD_BYTE, CH_CR);
		send(CMD_BYTE, CH_LF);
		repeat ($urandom_range(2))
			send_header_line();
		send(CMD_BYTE, CH_CR);
		send(CMD_BYTE, CH_LF);
		repeat ($urandom_range(4))
			send(CMD_BYTE, 8'($urandom_range(255)));
	endtask

	task automatic run_phase(int s_idle, int r_idle);
		int goal;
		goal = sent + PHASE_BYTES;
		send_idle = s_idle;
		recv_idle = r_idle;
		while (sent < goal)
			send_response();
		drain();
	endtask

	always @(posedge clk)
		out_stall <= ($urandom_range(99) < recv_idle);

	always @(posedge clk) begin : rx_check
		word_t want;
		if (arst_n && out_valid === 1'b1 && !out_stall) begin
			if (pending.size() == 0) begin
				$display("%0t: unexpected result word, expected none, got role %0d byte %02h",
					$time, role, out_byte);
				errors++;
			end else begin
				want = pending.pop_front();
				check_field("role", 17'(want.role), 17'(role));
				check_field("out_byte", 17'(want.octet), 17'(out_byte));
				check_field("status_code", want.status, status_code);
				check_field("separators_seen", 17'(want.seps), 17'(separators_seen));
				check_field("colon_seen", 17'(want.colon), 17'(colon_seen));
				check_field("trim_overflow", 17'(want.trim), 17'(trim_overflow));
				check_field("last", 17'(want.last), 17'(last));
				words++;
				if (want.role == ROLE_HDR_END)
					hdr_ends++;
				if (want.role == ROLE_LINE_END && want.trim)
					trim_lines++;
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
			quiet <= 0;
		else if (quiet >= QUIET_LIMIT) begin
			$display("[http_response_header_parser] ERROR");
			$finish;
		end else
			quiet <= quiet + 1;
	end

	initial begin
		reset_parser();
		script = '{
			row(CMD_RESTART, 8'hFF),
			row_exp("H", ROLE_VERSION, "H", '0, '0),
			row(CMD_BYTE, CH_SP),
			row(CMD_BYTE, CH_MINUS),
			row(CMD_BYTE, "7"),
			row(CMD_BYTE, "0"),
			row(CMD_BYTE, "0"),
			row(CMD_BYTE, "0"),
			row(CMD_BYTE, "0"),
			row(CMD_BYTE, CH_SP),
			// bare LF is just a reason byte
			row_exp(CH_LF, ROLE_REASON, CH_LF, '0, '0),
			row(CMD_BYTE, CH_CR),
			// -70000 saturates
			row_exp(CH_LF, ROLE_START_END, 8'h00, -17'sd65535, 2'd2),
			row_exp("a", ROLE_NAME, "a", '0, '0),
			row(CMD_BYTE, CH_COLON),
			row(CMD_BYTE, CH_SP),
			row(CMD_BYTE, "v"),
			row(CMD_BYTE, CH_TAB),
			row(CMD_BYTE, CH_CR),
			// CR CR: first one becomes value content, second is held again
			row(CMD_BYTE, CH_CR),
			row(CMD_BYTE, CH_LF),
			row(CMD_BYTE, CH_CR),
			row_exp(CH_LF, ROLE_HDR_END, 8'h00, '0, '0),
			row_exp(8'hFF, ROLE_BODY, 8'hFF, '0, '0),
			row(CMD_RESTART, 8'h00),
			row(CMD_BYTE, CH_CR),
			// empty first line ends the header straight away
			row_exp(CH_LF, ROLE_HDR_END, 8'h00, '0, '0)
		};
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		foreach (script[i])
			send(script[i].cmd, script[i].octet, script[i].typed, script[i].want);
		drain();
		run_phase(35, 86);
		run_phase(86, 35);
		run_phase(0, 0);
		repeat (TAIL) @(posedge clk);
		$display("Drove %0d input words through scripted and generated responses, checking %0d",
			sent, words);
		$display("result words (%0d header ends, %0d lines with trim overflow).",
			hdr_ends, trim_lines);
		if (errors == 0)
			$display("[http_response_header_parser] OK");
		else
			$display("[http_response_header_parser] ERROR");
		$finish;
	end

endmodule

// ===== sim.f =====
hdl/hrhp_pkg.sv
hdl/hrhp_dp.sv
hdl/hrhp_ctrl.sv
hdl/http_response_header_parser.sv
tb/tb_http_response_header_parser.sv
